/* src/hkse_pkg.sv */
// ----------------------------------------------------------------------------
// hkse_pkg
// Shared types and constants for the heap k-smallest extractor.
// ----------------------------------------------------------------------------
package hkse_pkg;

  localparam int unsigned VAL_W  = 32;  // heap value width
  localparam int unsigned IDX_W  = 6;   // entry index field width
  localparam int unsigned SIZE_W = 7;   // heap_size register width
  localparam int unsigned ACT_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE   = 2'd0,
    ACT_EXTRACT = 2'd1,
    ACT_RESTART = 2'd2
  } action_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_POP,
    S_POP_LAST,
    S_LAST_POS,
    S_LAST_KEY,
    S_DN_CHK,
    S_DN_LPOS,
    S_DN_LKEY,
    S_DN_RPOS,
    S_DN_RKEY,
    S_DN_MOVE,
    S_DN_PLACE,
    S_RES_RD,
    S_RES_VAL,
    S_PUSH_CHK,
    S_PUSH_KEY,
    S_UP_CHK,
    S_UP_PPOS,
    S_UP_PKEY,
    S_UP_PLACE,
    S_PUSH_NEXT,
    S_FINISH
  } state_e;

endpackage

/* src/hkse_if.sv */
// ----------------------------------------------------------------------------
// hkse channel interfaces
// Request, response and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hkse_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [hkse_pkg::ACT_W-1:0]           action;
  logic [hkse_pkg::IDX_W-1:0]           entry_index;
  logic signed [hkse_pkg::VAL_W-1:0]    entry_value;

  modport source (output valid, action, entry_index, entry_value, input ready);
  modport sink   (input valid, action, entry_index, entry_value, output ready);
endinterface

interface hkse_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hkse_pkg::VAL_W-1:0]    smallest_value;
  logic                                 is_empty;

  modport source (output valid, smallest_value, is_empty, input ready);
  modport sink   (input valid, smallest_value, is_empty, output ready);
endinterface

interface hkse_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [hkse_pkg::SIZE_W-1:0]          heap_size;

  modport source (output valid, heap_size, input ready);
  modport sink   (input valid, heap_size, output ready);
endinterface

/* src/hkse_ram.sv */
// ----------------------------------------------------------------------------
// hkse_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hkse_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* src/heap_k_smallest_extractor.sv */
// ----------------------------------------------------------------------------
// heap_k_smallest_extractor
// Returns the values of a loaded binary min-heap in ascending order, one per
// extract, by way of a frontier heap of positions.
// ----------------------------------------------------------------------------
// Writes and restarts give no result; an extract that finds nothing left
// returns an empty result. Any other extract returns one result. Each store
// has a single read port, so every key fetch of a frontier entry is a
// frontier slot read followed by a heap value read. The first extract reads
// the root; a later one pops the frontier top and sifts the last frontier
// entry down from the top. Each of the result's two children is then pushed,
// unless it lies beyond the heap or the frontier is full, and is sifted up.
// The request channel is ready only while the sequencer is idle; a finished
// result is held back only while the previous one still waits unaccepted in
// the output register. Values of heap positions never written are undefined.
// heap_size above HEAP_DEPTH acts as HEAP_DEPTH.
module heap_k_smallest_extractor #(
  parameter int unsigned HEAP_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hkse_req_if.sink   req_i,
  hkse_cfg_if.sink   cfg_i,
  hkse_rsp_if.source rsp_o
);

  localparam int unsigned POS_W = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CH_W  = POS_W + 2;
  localparam int unsigned VW    = hkse_pkg::VAL_W;

  hkse_pkg::state_e state_q, state_d;

  logic [hkse_pkg::SIZE_W-1:0] heap_size_q, heap_size_d;
  logic                        started_q, started_d;
  logic [CNT_W-1:0]            fcount_q, fcount_d;
  logic                        second_q, second_d;
  logic                        out_valid_q, out_valid_d;

  logic [POS_W-1:0]     slot_q, slot_d;
  logic [CH_W-1:0]      ch_q, ch_d;
  logic [POS_W-1:0]     x_pos_q, x_pos_d;
  logic signed [VW-1:0] x_key_q, x_key_d;
  logic [POS_W-1:0]     tmp_pos_q, tmp_pos_d;
  logic [POS_W-1:0]     best_pos_q, best_pos_d;
  logic signed [VW-1:0] best_key_q, best_key_d;
  logic [POS_W-1:0]     best_slot_q, best_slot_d;
  logic                 best_move_q, best_move_d;
  logic [POS_W-1:0]     res_pos_q, res_pos_d;
  logic signed [VW-1:0] res_val_q, res_val_d;
  logic                 res_empty_q, res_empty_d;
  logic signed [VW-1:0] out_val_q, out_val_d;
  logic                 out_empty_q, out_empty_d;

  // store ports
  logic             heap_we, fr_we;
  logic [POS_W-1:0] heap_wa, heap_ra, fr_wa, fr_ra, fr_wd, fr_rd;
  logic [VW-1:0]    heap_wd, heap_rd_raw;
  logic signed [VW-1:0] heap_rd;

  // shared comparator
  logic signed [VW-1:0] cmp_a, cmp_b;
  logic                 cmp_lt;

  logic [CNT_W-1:0] live_size;
  logic [CH_W-1:0]  dn_l, dn_r;
  logic [POS_W-1:0] up_parent;

  hkse_ram #(.DEPTH(HEAP_DEPTH), .WIDTH(VW)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_wa),
    .wdata_i (heap_wd),
    .raddr_i (heap_ra),
    .rdata_o (heap_rd_raw)
  );

  hkse_ram #(.DEPTH(HEAP_DEPTH), .WIDTH(POS_W)) u_frontier_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_wa),
    .wdata_i (fr_wd),
    .raddr_i (fr_ra),
    .rdata_o (fr_rd)
  );

  assign heap_rd = signed'(heap_rd_raw);
  assign cmp_lt  = cmp_a < cmp_b;

  always_comb begin
    if (32'(heap_size_q) > HEAP_DEPTH) begin
      live_size = CNT_W'(HEAP_DEPTH);
    end else begin
      live_size = CNT_W'(heap_size_q);
    end
  end

  assign dn_l      = {1'b0, slot_q, 1'b1};
  assign dn_r      = dn_l + CH_W'(1);
  assign up_parent = (slot_q - POS_W'(1)) >> 1;

  assign req_i.ready          = (state_q == hkse_pkg::S_IDLE);
  assign cfg_i.ready          = 1'b1;
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.smallest_value = out_val_q;
  assign rsp_o.is_empty       = out_empty_q;

  always_comb begin
    state_d     = state_q;
    heap_size_d = heap_size_q;
    started_d   = started_q;
    fcount_d    = fcount_q;
    second_d    = second_q;
    slot_d      = slot_q;
    ch_d        = ch_q;
    x_pos_d     = x_pos_q;
    x_key_d     = x_key_q;
    tmp_pos_d   = tmp_pos_q;
    best_pos_d  = best_pos_q;
    best_key_d  = best_key_q;
    best_slot_d = best_slot_q;
    best_move_d = best_move_q;
    res_pos_d   = res_pos_q;
    res_val_d   = res_val_q;
    res_empty_d = res_empty_q;
    out_val_d   = out_val_q;
    out_empty_d = out_empty_q;
    out_valid_d = out_valid_q && !rsp_o.ready;

    heap_we = 1'b0;
    heap_wa = POS_W'(req_i.entry_index);
    heap_wd = req_i.entry_value;
    heap_ra = '0;
    fr_we   = 1'b0;
    fr_wa   = slot_q;
    fr_wd   = x_pos_q;
    fr_ra   = '0;
    cmp_a   = heap_rd;
    cmp_b   = x_key_q;

    if (cfg_i.valid) begin
      heap_size_d = cfg_i.heap_size;
    end

    unique case (state_q)
      hkse_pkg::S_IDLE: begin
        if (req_i.valid) begin
          unique case (hkse_pkg::action_e'(req_i.action))
            hkse_pkg::ACT_WRITE: begin
              heap_we = (32'(req_i.entry_index) < HEAP_DEPTH);
            end
            hkse_pkg::ACT_RESTART: begin
              fcount_d  = '0;
              started_d = 1'b0;
            end
            hkse_pkg::ACT_EXTRACT: begin
              if (!started_q && live_size == '0) begin
                res_val_d   = '0;
                res_empty_d = 1'b1;
                state_d     = hkse_pkg::S_FINISH;
              end else if (!started_q) begin
                // root first, then its children seed the frontier
                started_d = 1'b1;
                fcount_d  = '0;
                res_pos_d = '0;
                state_d   = hkse_pkg::S_RES_RD;
              end else if (fcount_q == '0) begin
                res_val_d   = '0;
                res_empty_d = 1'b1;
                state_d     = hkse_pkg::S_FINISH;
              end else begin
                state_d = hkse_pkg::S_POP;
              end
            end
            default: ;
          endcase
        end
      end
      hkse_pkg::S_POP: begin
        fr_ra    = '0;
        fcount_d = fcount_q - CNT_W'(1);
        state_d  = hkse_pkg::S_POP_LAST;
      end
      hkse_pkg::S_POP_LAST: begin
        res_pos_d = fr_rd;
        if (fcount_q == '0) begin
          state_d = hkse_pkg::S_RES_RD;
        end else begin
          fr_ra   = POS_W'(fcount_q);
          state_d = hkse_pkg::S_LAST_POS;
        end
      end
      hkse_pkg::S_LAST_POS: begin
        x_pos_d = fr_rd;
        heap_ra = fr_rd;
        state_d = hkse_pkg::S_LAST_KEY;
      end
      hkse_pkg::S_LAST_KEY: begin
        // last entry is carried as a hole from the root downwards
        x_key_d = heap_rd;
        slot_d  = '0;
        state_d = hkse_pkg::S_DN_CHK;
      end
      hkse_pkg::S_DN_CHK: begin
        if (32'(dn_l) < 32'(fcount_q)) begin
          fr_ra   = POS_W'(dn_l);
          state_d = hkse_pkg::S_DN_LPOS;
        end else begin
          state_d = hkse_pkg::S_DN_PLACE;
        end
      end
      hkse_pkg::S_DN_LPOS: begin
        tmp_pos_d = fr_rd;
        heap_ra   = fr_rd;
        state_d   = hkse_pkg::S_DN_LKEY;
      end
      hkse_pkg::S_DN_LKEY: begin
        cmp_a = heap_rd;
        cmp_b = x_key_q;
        if (cmp_lt) begin
          best_move_d = 1'b1;
          best_key_d  = heap_rd;
          best_pos_d  = tmp_pos_q;
          best_slot_d = POS_W'(dn_l);
        end else begin
          best_move_d = 1'b0;
          best_key_d  = x_key_q;
        end
        if (32'(dn_r) < 32'(fcount_q)) begin
          fr_ra   = POS_W'(dn_r);
          state_d = hkse_pkg::S_DN_RPOS;
        end else begin
          state_d = hkse_pkg::S_DN_MOVE;
        end
      end
      hkse_pkg::S_DN_RPOS: begin
        tmp_pos_d = fr_rd;
        heap_ra   = fr_rd;
        state_d   = hkse_pkg::S_DN_RKEY;
      end
      hkse_pkg::S_DN_RKEY: begin
        cmp_a = heap_rd;
        cmp_b = best_key_q;
        if (cmp_lt) begin
          best_move_d = 1'b1;
          best_pos_d  = tmp_pos_q;
          best_slot_d = POS_W'(dn_r);
        end
        state_d = hkse_pkg::S_DN_MOVE;
      end
      hkse_pkg::S_DN_MOVE: begin
        if (best_move_q) begin
          fr_we   = 1'b1;
          fr_wd   = best_pos_q;
          slot_d  = best_slot_q;
          state_d = hkse_pkg::S_DN_CHK;
        end else begin
          state_d = hkse_pkg::S_DN_PLACE;
        end
      end
      hkse_pkg::S_DN_PLACE: begin
        fr_we   = 1'b1;
        state_d = hkse_pkg::S_RES_RD;
      end
      hkse_pkg::S_RES_RD: begin
        heap_ra = res_pos_q;
        state_d = hkse_pkg::S_RES_VAL;
      end
      hkse_pkg::S_RES_VAL: begin
        res_val_d   = heap_rd;
        res_empty_d = 1'b0;
        ch_d        = {1'b0, res_pos_q, 1'b1};
        second_d    = 1'b0;
        state_d     = hkse_pkg::S_PUSH_CHK;
      end
      hkse_pkg::S_PUSH_CHK: begin
        if (32'(ch_q) < 32'(live_size) && 32'(fcount_q) < HEAP_DEPTH) begin
          x_pos_d  = POS_W'(ch_q);
          heap_ra  = POS_W'(ch_q);
          slot_d   = POS_W'(fcount_q);
          fcount_d = fcount_q + CNT_W'(1);
          state_d  = hkse_pkg::S_PUSH_KEY;
        end else begin
          state_d = hkse_pkg::S_PUSH_NEXT;
        end
      end
      hkse_pkg::S_PUSH_KEY: begin
        x_key_d = heap_rd;
        state_d = hkse_pkg::S_UP_CHK;
      end
      hkse_pkg::S_UP_CHK: begin
        if (slot_q == '0) begin
          state_d = hkse_pkg::S_UP_PLACE;
        end else begin
          fr_ra   = up_parent;
          state_d = hkse_pkg::S_UP_PPOS;
        end
      end
      hkse_pkg::S_UP_PPOS: begin
        tmp_pos_d = fr_rd;
        heap_ra   = fr_rd;
        state_d   = hkse_pkg::S_UP_PKEY;
      end
      hkse_pkg::S_UP_PKEY: begin
        cmp_a = x_key_q;
        cmp_b = heap_rd;
        if (cmp_lt) begin
          // parent moves down into the hole
          fr_we   = 1'b1;
          fr_wd   = tmp_pos_q;
          slot_d  = up_parent;
          state_d = hkse_pkg::S_UP_CHK;
        end else begin
          state_d = hkse_pkg::S_UP_PLACE;
        end
      end
      hkse_pkg::S_UP_PLACE: begin
        fr_we   = 1'b1;
        state_d = hkse_pkg::S_PUSH_NEXT;
      end
      hkse_pkg::S_PUSH_NEXT: begin
        if (!second_q) begin
          second_d = 1'b1;
          ch_d     = ch_q + CH_W'(1);
          state_d  = hkse_pkg::S_PUSH_CHK;
        end else begin
          state_d = hkse_pkg::S_FINISH;
        end
      end
      hkse_pkg::S_FINISH: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_empty_d = res_empty_q;
          state_d     = hkse_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = hkse_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hkse_pkg::S_IDLE;
      heap_size_q <= '0;
      started_q   <= 1'b0;
      fcount_q    <= '0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      heap_size_q <= heap_size_d;
      started_q   <= started_d;
      fcount_q    <= fcount_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    ch_q        <= ch_d;
    x_pos_q     <= x_pos_d;
    x_key_q     <= x_key_d;
    tmp_pos_q   <= tmp_pos_d;
    best_pos_q  <= best_pos_d;
    best_key_q  <= best_key_d;
    best_slot_q <= best_slot_d;
    best_move_q <= best_move_d;
    res_pos_q   <= res_pos_d;
    res_val_q   <= res_val_d;
    res_empty_q <= res_empty_d;
    out_val_q   <= out_val_d;
    out_empty_q <= out_empty_d;
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcount_q <= CNT_W'(HEAP_DEPTH))
    else $error("frontier count beyond depth");

  a_idle_frontier : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> fcount_q == '0)
    else $error("frontier holds entries before extraction started");

  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_empty_q |-> out_val_q == '0)
    else $error("empty result carries a nonzero value");

  a_rsp_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == hkse_pkg::S_FINISH))
    else $error("result beat raised outside the finish step");

endmodule
